/* hw/rtl/mouse_delta_acceleration_assert.svh */
// ----------------------------------------------------------------------------
// Mouse delta acceleration assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef MOUSE_DELTA_ACCELERATION_ASSERT_SVH
`define MOUSE_DELTA_ACCELERATION_ASSERT_SVH

`ifndef SYNTHESIS
`define MDA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) else $error(msg);
`define MDA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) else $error(msg);
`else
`define MDA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MDA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hw/rtl/mda_pkg.sv */
// ----------------------------------------------------------------------------
// Mouse delta acceleration package
// Word types and fixed constants shared by the acceleration pipeline.
// ----------------------------------------------------------------------------
package mda_pkg;

  localparam int THR_W     = 8;
  localparam int FAC_W     = 6;
  localparam int DELTA_W   = 8;
  localparam int DIV_W     = 6;
  localparam int Q_W       = 7;
  localparam int NUM_W     = DELTA_W + DIV_W - 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [FAC_W-1:0]     FAC_MAX  = 6'd40;
  localparam logic [DIV_W-1:0]     DIV_BASE = 6'd41;
  localparam logic [DELTA_W-1:0]   SAT_MAG  = 8'd127;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 2'd1;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
  } in_word_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] scaled_x;
    logic signed [DELTA_W-1:0] scaled_y;
  } out_word_t;

endpackage

/* hw/rtl/mda_axis.sv */
// ----------------------------------------------------------------------------
// Mouse delta acceleration, one axis
// Curve lookup, restoring divide over three stages, saturate and sign.
// ----------------------------------------------------------------------------
module mda_axis #(
  parameter int CURVE_POINTS = 6
) (
  input  logic                                       clk,
  input  logic signed [mda_pkg::DELTA_W-1:0]         delta,
  input  logic [mda_pkg::THR_W*CURVE_POINTS-1:0]     thr_table,
  input  logic [mda_pkg::FAC_W*CURVE_POINTS-1:0]     fac_table,
  output logic signed [mda_pkg::DELTA_W-1:0]         scaled
);

  localparam int DW = mda_pkg::DELTA_W;
  localparam int VW = mda_pkg::DIV_W;
  localparam int NW = mda_pkg::NUM_W;
  localparam int QW = mda_pkg::Q_W;

  // stage 1: magnitude, curve point, divisor
  logic          neg_s1_r, neg_s1_nxt;
  logic          hit_s1_r, hit_s1_nxt;
  logic [DW-1:0] mag_s1_r, mag_s1_nxt;
  logic [VW-1:0] div_s1_r, div_s1_nxt;

  // stage 2: numerator, saturation, quotient bits 6..5
  logic          neg_s2_r, neg_s2_nxt;
  logic          hit_s2_r, hit_s2_nxt;
  logic          sat_s2_r, sat_s2_nxt;
  logic [DW-1:0] mag_s2_r, mag_s2_nxt;
  logic [VW-1:0] div_s2_r, div_s2_nxt;
  logic [NW-1:0] rem_s2_r, rem_s2_nxt;
  logic [QW-1:0] quo_s2_r, quo_s2_nxt;

  // stage 3: quotient bits 4..2
  logic          neg_s3_r, neg_s3_nxt;
  logic          hit_s3_r, hit_s3_nxt;
  logic          sat_s3_r, sat_s3_nxt;
  logic [DW-1:0] mag_s3_r, mag_s3_nxt;
  logic [VW-1:0] div_s3_r, div_s3_nxt;
  logic [NW-1:0] rem_s3_r, rem_s3_nxt;
  logic [QW-1:0] quo_s3_r, quo_s3_nxt;

  // stage 4: quotient bits 1..0, format
  logic signed [DW-1:0] scaled_r, scaled_nxt;

  always_comb begin
    logic [DW-1:0]                 raw;
    logic [mda_pkg::FAC_W-1:0]     fac;
    logic [mda_pkg::FAC_W-1:0]     fac_clip;
    raw        = delta;
    neg_s1_nxt = raw[DW-1];
    mag_s1_nxt = raw[DW-1] ? (DW'(0) - raw) : raw;
    hit_s1_nxt = 1'b0;
    fac        = '0;
    for (int i = 0; i < CURVE_POINTS; i++) begin
      if (mag_s1_nxt >= thr_table[i*mda_pkg::THR_W +: mda_pkg::THR_W]) begin
        hit_s1_nxt = 1'b1;
        fac        = fac_table[i*mda_pkg::FAC_W +: mda_pkg::FAC_W];
      end
    end
    fac_clip   = (fac > mda_pkg::FAC_MAX) ? mda_pkg::FAC_MAX : fac;
    div_s1_nxt = mda_pkg::DIV_BASE - VW'(fac_clip);
  end

  always_comb begin
    logic [NW-1:0] num;
    num        = NW'({mag_s1_r, 5'b0}) + NW'({mag_s1_r, 3'b0});
    neg_s2_nxt = neg_s1_r;
    hit_s2_nxt = hit_s1_r;
    mag_s2_nxt = mag_s1_r;
    div_s2_nxt = div_s1_r;
    sat_s2_nxt = num >= {div_s1_r, 7'b0};
    rem_s2_nxt = num;
    quo_s2_nxt = '0;
    for (int k = 6; k >= 5; k--) begin
      if (rem_s2_nxt >= (NW'(div_s1_r) << k)) begin
        rem_s2_nxt = rem_s2_nxt - (NW'(div_s1_r) << k);
        quo_s2_nxt[k] = 1'b1;
      end
    end
  end

  always_comb begin
    neg_s3_nxt = neg_s2_r;
    hit_s3_nxt = hit_s2_r;
    sat_s3_nxt = sat_s2_r;
    mag_s3_nxt = mag_s2_r;
    div_s3_nxt = div_s2_r;
    rem_s3_nxt = rem_s2_r;
    quo_s3_nxt = quo_s2_r;
    for (int k = 4; k >= 2; k--) begin
      if (rem_s3_nxt >= (NW'(div_s2_r) << k)) begin
        rem_s3_nxt = rem_s3_nxt - (NW'(div_s2_r) << k);
        quo_s3_nxt[k] = 1'b1;
      end
    end
  end

  always_comb begin
    logic [NW-1:0] rem;
    logic [QW-1:0] quo;
    logic [DW-1:0] res;
    rem = rem_s3_r;
    quo = quo_s3_r;
    for (int k = 1; k >= 0; k--) begin
      if (rem >= (NW'(div_s3_r) << k)) begin
        rem    = rem - (NW'(div_s3_r) << k);
        quo[k] = 1'b1;
      end
    end
    if (hit_s3_r) begin
      res = sat_s3_r ? mda_pkg::SAT_MAG : DW'(quo);
    end else begin
      res = (mag_s3_r > mda_pkg::SAT_MAG) ? mda_pkg::SAT_MAG : mag_s3_r;
    end
    scaled_nxt = neg_s3_r ? (DW'(0) - res) : res;
  end

  always_ff @(posedge clk) begin
    neg_s1_r <= neg_s1_nxt;
    hit_s1_r <= hit_s1_nxt;
    mag_s1_r <= mag_s1_nxt;
    div_s1_r <= div_s1_nxt;
    neg_s2_r <= neg_s2_nxt;
    hit_s2_r <= hit_s2_nxt;
    sat_s2_r <= sat_s2_nxt;
    mag_s2_r <= mag_s2_nxt;
    div_s2_r <= div_s2_nxt;
    rem_s2_r <= rem_s2_nxt;
    quo_s2_r <= quo_s2_nxt;
    neg_s3_r <= neg_s3_nxt;
    hit_s3_r <= hit_s3_nxt;
    sat_s3_r <= sat_s3_nxt;
    mag_s3_r <= mag_s3_nxt;
    div_s3_r <= div_s3_nxt;
    rem_s3_r <= rem_s3_nxt;
    quo_s3_r <= quo_s3_nxt;
    scaled_r <= scaled_nxt;
  end

  assign scaled = scaled_r;

endmodule

/* hw/rtl/mouse_delta_acceleration.sv */
// ----------------------------------------------------------------------------
// Mouse delta acceleration
// Per-axis pointer acceleration curve for relative mouse packets.
//
// Input: pulse start with a packet on in_word; busy is always low, so a
// word is taken on every cycle that start is high.
// Output: out_strobe marks out_word for exactly one cycle, once the word
// has passed the four register stages; out_word is valid while it is high.
// One word enters and one word leaves per cycle.
// The four register stages perform the curve lookup, then a
// restoring divide by (41 - factor) that retires two, three and two quotient
// bits per stage, then saturate and sign.
// Configuration: cfg_we writes register cfg_index from cfg_wdata
// (0 = threshold table, 1 = factor table, others ignored). Write only while
// no packet is in flight.
// Reset clears both tables and drops any words in flight.
// The receiver cannot stall; every result is presented once.
// ----------------------------------------------------------------------------
module mouse_delta_acceleration #(
  parameter int CURVE_POINTS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  mda_pkg::in_word_t                      in_word,
  output logic                                   out_strobe,
  output mda_pkg::out_word_t                     out_word,
  input  logic                                   cfg_we,
  input  logic [mda_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mda_pkg::THR_W*CURVE_POINTS-1:0] cfg_wdata
);

  `include "mouse_delta_acceleration_assert.svh"

  localparam int TW     = mda_pkg::THR_W * CURVE_POINTS;
  localparam int FW     = mda_pkg::FAC_W * CURVE_POINTS;
  localparam int STAGES = 4;

  logic [TW-1:0]     thr_r, thr_nxt;
  logic [FW-1:0]     fac_r, fac_nxt;
  logic [STAGES-1:0] vld_r, vld_nxt;
  logic              fire;

  assign busy = 1'b0;
  assign fire = start && !busy;

  always_comb begin
    thr_nxt = thr_r;
    fac_nxt = fac_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mda_pkg::REG_THRESHOLD: thr_nxt = cfg_wdata;
        mda_pkg::REG_FACTOR:    fac_nxt = cfg_wdata[FW-1:0];
        default: ;
      endcase
    end
    vld_nxt = {vld_r[STAGES-2:0], fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      fac_r <= '0;
      vld_r <= '0;
    end else begin
      thr_r <= thr_nxt;
      fac_r <= fac_nxt;
      vld_r <= vld_nxt;
    end
  end

  mda_axis #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_axis_x (
    .clk       (clk),
    .delta     (in_word.delta_x),
    .thr_table (thr_r),
    .fac_table (fac_r),
    .scaled    (out_word.scaled_x)
  );

  mda_axis #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_axis_y (
    .clk       (clk),
    .delta     (in_word.delta_y),
    .thr_table (thr_r),
    .fac_table (fac_r),
    .scaled    (out_word.scaled_y)
  );

  assign out_strobe = vld_r[STAGES-1];

  `MDA_ASSERT_NXT(a_latency, clk, rst_n, fire, ##3 out_strobe, "result missing after accept")
  `MDA_ASSERT_IMP(a_no_min, clk, rst_n, out_strobe, (out_word.scaled_x != 8'h80) && (out_word.scaled_y != 8'h80), "result outside saturation range")
  `MDA_ASSERT_IMP(a_zero, clk, rst_n, fire && (in_word.delta_x == 8'h00), ##4 (out_word.scaled_x == 8'h00), "zero delta not kept")
  `MDA_ASSERT_IMP(a_rst_quiet, clk, rst_n, $past(!rst_n), !out_strobe, "strobe right after reset")

endmodule

/* bench/mda_accel_checker.sv */
// ----------------------------------------------------------------------------
// Mouse delta acceleration checker
// Watches the packet, result and register ports of the acceleration block.
// It keeps its own copy of both curve tables and works out the scaled
// deltas of every accepted packet. Each strobed result is then compared,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mda_accel_checker #(
  parameter int CURVE_POINTS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  mda_pkg::in_word_t                      in_word,
  input  logic                                   out_strobe,
  input  mda_pkg::out_word_t                     out_word,
  input  logic                                   cfg_we,
  input  logic [mda_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mda_pkg::THR_W*CURVE_POINTS-1:0] cfg_wdata,
  output int                                     mismatch_count,
  output int                                     words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import mda_pkg::*;

  localparam int TABLE_W = THR_W * CURVE_POINTS;

  logic [TABLE_W-1:0] thr_table;
  logic [TABLE_W-1:0] fac_table;
  out_word_t          scaled_due[$];

  function automatic logic [DELTA_W-1:0] scale_axis(logic [DELTA_W-1:0] delta);
    int                 mag;
    int                 divisor;
    logic [FAC_W-1:0]   fac;
    logic               neg;
    logic               hit;
    logic [DELTA_W-1:0] res;
    neg = delta[DELTA_W-1];
    mag = int'(delta);
    if (neg) mag = (1 << DELTA_W) - mag;
    hit = 1'b0;
    for (int i = CURVE_POINTS - 1; i >= 0; i--) begin
      if (!hit && mag >= int'(thr_table[THR_W*i +: THR_W])) begin
        hit = 1'b1;
        fac = fac_table[FAC_W*i +: FAC_W];
        if (fac > FAC_MAX) fac = FAC_MAX;
        divisor = (int'(DIV_BASE) - int'(fac)) * 10;
        mag = mag * 400 / divisor;
      end
    end
    if (mag > int'(SAT_MAG)) mag = int'(SAT_MAG);
    res = mag[DELTA_W-1:0];
    if (neg) res = -res;
    return res;
  endfunction

  always @(posedge clk) begin
    out_word_t due;
    if (!rst_n) begin
      thr_table      = '0;
      fac_table      = '0;
      scaled_due.delete();
      mismatch_count = 0;
      words_due      = 0;
    end else begin
      if (out_strobe) begin
        if (scaled_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none, actual x=%0d y=%0d",
                   $time, out_word.scaled_x, out_word.scaled_y);
        end else begin
          due = scaled_due.pop_front();
          if (out_word.scaled_x !== due.scaled_x) begin
            mismatch_count++;
            $display("%0t: scaled_x mismatch, expected %0d, actual %0d",
                     $time, due.scaled_x, out_word.scaled_x);
          end
          if (out_word.scaled_y !== due.scaled_y) begin
            mismatch_count++;
            $display("%0t: scaled_y mismatch, expected %0d, actual %0d",
                     $time, due.scaled_y, out_word.scaled_y);
          end
        end
      end
      if (start && !busy) begin
        due.scaled_x = scale_axis(in_word.delta_x);
        due.scaled_y = scale_axis(in_word.delta_y);
        scaled_due.push_back(due);
      end
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) thr_table = cfg_wdata;
        else if (cfg_index == REG_FACTOR) fac_table = cfg_wdata;
      end
      words_due = scaled_due.size();
    end
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Mouse delta acceleration testbench
// Drives packets into the acceleration block under a series of curve
// settings: reset tables, saturating and never-matching extremes, a hand
// built curve, ignored register writes and random curves. Packet gaps vary
// by phase; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mda_pkg::*;

  localparam int CURVE_POINTS = 6;
  localparam int CFG_W        = THR_W * CURVE_POINTS;
  localparam int FLUSH_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 62;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_word_t             in_word;
  logic                 out_strobe;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatch_count;
  int                   words_due;
  int                   idle_cycles = 0;

  mouse_delta_acceleration #(
    .CURVE_POINTS(CURVE_POINTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mda_accel_checker #(
    .CURVE_POINTS(CURVE_POINTS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_word       (in_word),
    .out_strobe    (out_strobe),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .words_due     (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (FLUSH_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_packet(logic signed [DELTA_W-1:0] dx,
                             logic signed [DELTA_W-1:0] dy, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start           <= 1'b1;
    in_word.delta_x <= dx;
    in_word.delta_y <= dy;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [DELTA_W-1:0] random_delta();
    logic signed [DELTA_W-1:0] d;
    int                        pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      d = DELTA_W'($urandom_range(255));
    end else if (pick < 85) begin
      d = DELTA_W'($urandom_range(32));
      if ($urandom_range(1)) d = -d;
    end else begin
      case ($urandom_range(6))
        0:       d = -8'sd128;
        1:       d = -8'sd127;
        2:       d = -8'sd1;
        3:       d = 8'sd0;
        4:       d = 8'sd1;
        5:       d = 8'sd126;
        default: d = 8'sd127;
      endcase
    end
    return d;
  endfunction

  function automatic logic [CFG_W-1:0] random_thresholds();
    logic [CFG_W-1:0] t;
    int               acc;
    t   = '0;
    acc = 0;
    if ($urandom_range(3) == 0) begin
      t = CFG_W'({$urandom, $urandom});
    end else begin
      for (int i = 0; i < CURVE_POINTS; i++) begin
        acc += $urandom_range(40);
        if (acc > 255) acc = 255;
        t[THR_W*i +: THR_W] = acc[THR_W-1:0];
      end
    end
    return t;
  endfunction

  function automatic logic [CFG_W-1:0] random_factors();
    logic [CFG_W-1:0] f;
    logic [FAC_W-1:0] v;
    f = CFG_W'({$urandom, $urandom});
    for (int i = 0; i < CURVE_POINTS; i++) begin
      if ($urandom_range(99) < 80) v = FAC_W'($urandom_range(int'(FAC_MAX)));
      else v = FAC_W'($urandom_range(63, int'(FAC_MAX) + 1));
      f[FAC_W*i +: FAC_W] = v;
    end
    return f;
  endfunction

  initial begin
    int idle_pct;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset tables: every magnitude scaled by 400/410
    send_packet(8'sd0, 8'sd0, 0);
    send_packet(8'sd127, -8'sd128, 0);
    send_packet(-8'sd128, 8'sd127, 0);
    send_packet(8'sd1, -8'sd1, 0);
    send_packet(-8'sd1, 8'sd1, 0);
    send_packet(8'sd64, -8'sd64, 0);
    send_packet(8'sd126, -8'sd127, 0);

    // gain of forty everywhere, saturate early
    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_FACTOR, CFG_W'({CURVE_POINTS{FAC_MAX}}));
    send_packet(8'sd3, -8'sd3, 0);
    send_packet(8'sd4, -8'sd4, 0);
    send_packet(-8'sd128, 8'sd127, 0);
    send_packet(8'sd0, 8'sd1, 0);

    // no threshold reachable, factors above forty
    write_reg(REG_THRESHOLD, '1);
    write_reg(REG_FACTOR, '1);
    send_packet(-8'sd128, 8'sd127, 0);
    send_packet(8'sd5, -8'sd5, 0);

    // stepped curve
    write_reg(REG_THRESHOLD, {8'd120, 8'd80, 8'd40, 8'd20, 8'd10, 8'd0});
    write_reg(REG_FACTOR, CFG_W'({6'd1, 6'd20, 6'd25, 6'd30, 6'd35, 6'd40}));
    send_packet(8'sd10, 8'sd9, 0);
    send_packet(-8'sd120, 8'sd119, 0);
    send_packet(8'sd80, -8'sd79, 0);

    // writes to unmapped indexes leave the curve alone
    write_reg(REG_SPARE_A, CFG_W'({$urandom, $urandom}));
    write_reg(REG_SPARE_B, CFG_W'({$urandom, $urandom}));
    send_packet(8'sd50, -8'sd50, 0);
    send_packet(-8'sd1, 8'sd1, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_THRESHOLD, '1);
          write_reg(REG_FACTOR, '0);
        end
        1: begin
          write_reg(REG_THRESHOLD, '0);
          write_reg(REG_FACTOR, '1);
        end
        default: begin
          write_reg(REG_THRESHOLD, random_thresholds());
          write_reg(REG_FACTOR, random_factors());
        end
      endcase
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 82;
        default: idle_pct = 17;
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_packet(random_delta(), random_delta(), idle_pct);
      end
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
